// ===== sv/sfr_pkg.sv =====
// Shared types, constants and helpers for the sensor frame resync parser.
// No dependencies.
package sfr_pkg;

  localparam int BUFFER_BYTES   = 64;
  localparam int FRAME_OVERHEAD = 5;
  localparam int ADDR_W         = 6;
  localparam int FILL_W         = 7;
  localparam int TOTAL_W        = 9;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_W         = 2;
  localparam int QCNT_W         = 3;

  localparam logic [7:0] TYPE_STATUS = 8'h11;
  localparam logic [7:0] TYPE_RADAR  = 8'h62;

  localparam logic [1:0] KIND_STATUS  = 2'd0;
  localparam logic [1:0] KIND_RADAR   = 2'd1;
  localparam logic [1:0] KIND_UNKNOWN = 2'd2;

  localparam logic REG_START_MARKER = 1'b0;
  localparam logic REG_END_MARKER   = 1'b1;

  // queued byte offered by the front part
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } q_head_t;

  // back part status seen at the top level
  typedef struct packed {
    logic [FILL_W-1:0] fill;
    logic              busy;
  } back_status_t;

  function automatic logic [1:0] kind_of(input logic [7:0] mtype);
    logic [1:0] k;
    if (mtype == TYPE_STATUS) begin
      k = KIND_STATUS;
    end else if (mtype == TYPE_RADAR) begin
      k = KIND_RADAR;
    end else begin
      k = KIND_UNKNOWN;
    end
    return k;
  endfunction

endpackage

// ===== sv/sfr_front.sv =====
// Front part: accepts received bytes into a short queue toward the back part.
// Depends on sfr_pkg.
module sfr_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_byte,
  output sfr_pkg::q_head_t q_head,
  input  logic             q_pop
);

  logic [7:0]                  qmem [sfr_pkg::QUEUE_DEPTH];
  logic [sfr_pkg::QPTR_W-1:0]  wptr;
  logic [sfr_pkg::QPTR_W-1:0]  rptr;
  logic [sfr_pkg::QCNT_W-1:0]  count;
  logic                        push;
  logic                        pop;

  assign in_stall    = (count == sfr_pkg::QCNT_W'(sfr_pkg::QUEUE_DEPTH));
  assign push        = in_valid && !in_stall;
  assign pop         = q_pop && (count != '0);
  assign q_head.valid = (count != '0);
  assign q_head.data  = qmem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wptr] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/sfr_back.sv =====
// Back part: circular byte buffer, start scan, checksum walk and frame emit.
// Depends on sfr_pkg.
module sfr_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           start_marker,
  input  logic [7:0]           end_marker,
  input  sfr_pkg::q_head_t     q_head,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_byte,
  output logic                 first_of_frame,
  output logic                 last_of_frame,
  output logic [7:0]           message_type,
  output logic [1:0]           frame_kind,
  output sfr_pkg::back_status_t status
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_PUSH     = 10'b0000000010,
    S_SKIP_RD  = 10'b0000000100,
    S_SKIP_CHK = 10'b0000001000,
    S_LEN_RD   = 10'b0000010000,
    S_LEN_CHK  = 10'b0000100000,
    S_SUM      = 10'b0001000000,
    S_CHK      = 10'b0010000000,
    S_EM_RD    = 10'b0100000000,
    S_EM_WR    = 10'b1000000000
  } state_t;

  state_t                         state;
  logic [7:0]                     store [sfr_pkg::BUFFER_BYTES];
  logic [7:0]                     rdata;
  logic [sfr_pkg::ADDR_W-1:0]     raddr;
  logic [sfr_pkg::ADDR_W-1:0]     head;
  logic [sfr_pkg::FILL_W-1:0]     fill;
  logic [7:0]                     pbyte;
  logic [sfr_pkg::TOTAL_W-1:0]    total;
  logic [sfr_pkg::TOTAL_W-1:0]    total_next;
  logic [sfr_pkg::FILL_W-1:0]     idx;
  logic [sfr_pkg::FILL_W-1:0]     pidx;
  logic                           pend;
  logic [7:0]                     sum;
  logic                           ck_ok;
  logic                           end_ok;
  logic [7:0]                     mtype;
  logic                           out_free;

  assign out_free   = !out_valid || !out_stall;
  assign q_pop      = (state == S_IDLE) && q_head.valid;
  assign total_next = sfr_pkg::TOTAL_W'(sfr_pkg::FRAME_OVERHEAD) + {1'b0, rdata};
  assign status.fill = fill;
  assign status.busy = (state != S_IDLE);

  always_comb begin
    case (state)
      S_LEN_RD: raddr = head + sfr_pkg::ADDR_W'(2);
      S_SUM:    raddr = head + idx[sfr_pkg::ADDR_W-1:0];
      S_EM_RD:  raddr = head + idx[sfr_pkg::ADDR_W-1:0];
      S_EM_WR:  raddr = head + idx[sfr_pkg::ADDR_W-1:0];
      default:  raddr = head;
    endcase
  end

  // buffer write on push; registered read every cycle
  always_ff @(posedge clk) begin
    if (state == S_PUSH) begin
      store[head + fill[sfr_pkg::ADDR_W-1:0]] <= pbyte;
    end
    rdata <= store[raddr];
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      pbyte <= q_head.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      // output register empties on a transfer unless emit refills it
      if (out_valid && !out_stall && (state != S_EM_WR)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_head.valid) begin
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          // full buffer: oldest byte is overwritten
          if (fill == sfr_pkg::FILL_W'(sfr_pkg::BUFFER_BYTES)) begin
            head <= head + 1'b1;
          end else begin
            fill <= fill + 1'b1;
          end
          state <= S_SKIP_RD;
        end
        S_SKIP_RD: begin
          state <= (fill == '0) ? S_IDLE : S_SKIP_CHK;
        end
        S_SKIP_CHK: begin
          if (rdata != start_marker) begin
            head  <= head + 1'b1;
            fill  <= fill - 1'b1;
            state <= S_SKIP_RD;
          end else if (fill < sfr_pkg::FILL_W'(sfr_pkg::FRAME_OVERHEAD)) begin
            state <= S_IDLE;
          end else begin
            state <= S_LEN_RD;
          end
        end
        S_LEN_RD: begin
          state <= S_LEN_CHK;
        end
        S_LEN_CHK: begin
          total <= total_next;
          if (total_next > sfr_pkg::TOTAL_W'(sfr_pkg::BUFFER_BYTES)) begin
            head  <= head + 1'b1;
            fill  <= fill - 1'b1;
            state <= S_SKIP_RD;
          end else if ({2'b00, fill} < total_next) begin
            state <= S_IDLE;
          end else begin
            idx   <= '0;
            pend  <= 1'b0;
            sum   <= '0;
            state <= S_SUM;
          end
        end
        S_SUM: begin
          if (pend) begin
            if ({2'b00, pidx} + 9'd2 < total) begin
              sum <= sum + rdata;
            end
            if ({2'b00, pidx} + 9'd2 == total) begin
              ck_ok <= (rdata == sum);
            end
            if ({2'b00, pidx} + 9'd1 == total) begin
              end_ok <= (rdata == end_marker);
            end
            if (pidx == sfr_pkg::FILL_W'(1)) begin
              mtype <= rdata;
            end
          end
          if ({2'b00, idx} == total) begin
            pend  <= 1'b0;
            state <= S_CHK;
          end else begin
            pend <= 1'b1;
            pidx <= idx;
            idx  <= idx + 1'b1;
          end
        end
        S_CHK: begin
          if (ck_ok && end_ok) begin
            idx   <= '0;
            state <= S_EM_RD;
          end else begin
            head  <= head + 1'b1;
            fill  <= fill - 1'b1;
            state <= S_SKIP_RD;
          end
        end
        S_EM_RD: begin
          state <= S_EM_WR;
        end
        S_EM_WR: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            out_byte       <= rdata;
            first_of_frame <= (idx == '0);
            last_of_frame  <= ({2'b00, idx} + 9'd1 == total);
            message_type   <= mtype;
            frame_kind     <= sfr_pkg::kind_of(mtype);
            if ({2'b00, idx} + 9'd1 == total) begin
              head  <= head + total[sfr_pkg::ADDR_W-1:0];
              fill  <= fill - total[sfr_pkg::FILL_W-1:0];
              state <= S_SKIP_RD;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_EM_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/sensor_frame_resync_parser.sv =====
// Sensor frame resync parser, top level: config registers, front queue, back part.
// A byte taken from the queue in IDLE is written in PUSH; a start-scan step is SKIP_RD
// then SKIP_CHK, the length read LEN_RD then LEN_CHK, the checksum walk SUM, and emit
// EM_RD then EM_WR per frame byte. Bytes pop only when idle; a 4-entry queue absorbs bursts.
// Reset (rst, synchronous): buffer empty, markers 0, no output pending; store is not cleared.
// Depends on sfr_pkg, sfr_front, sfr_back.
module sensor_frame_resync_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       first_of_frame,
  output logic       last_of_frame,
  output logic [7:0] message_type,
  output logic [1:0] frame_kind
);

  logic [7:0]            start_marker;
  logic [7:0]            end_marker;
  sfr_pkg::q_head_t      q_head;
  logic                  q_pop;
  sfr_pkg::back_status_t status;

  // config registers; to be written only while the parser is quiet (user's duty, not enforced)
  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= '0;
      end_marker   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sfr_pkg::REG_START_MARKER: start_marker <= cfg_data;
        sfr_pkg::REG_END_MARKER:   end_marker   <= cfg_data;
        default:                   start_marker <= start_marker;
      endcase
    end
  end

  // front: input transfer into the byte queue
  sfr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  // back: buffer, resync scan, checksum check, emit through output register
  sfr_back u_back (
    .clk            (clk),
    .rst            (rst),
    .start_marker   (start_marker),
    .end_marker     (end_marker),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .first_of_frame (first_of_frame),
    .last_of_frame  (last_of_frame),
    .message_type   (message_type),
    .frame_kind     (frame_kind),
    .status         (status)
  );

  // buffer never holds more than its depth
  assert property (@(posedge clk) disable iff (rst)
    status.fill <= sfr_pkg::FILL_W'(sfr_pkg::BUFFER_BYTES))
    else $error("buffer fill over depth");

  // after the last byte of a frame transfers, the next shown byte opens a frame
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last_of_frame) |=> (!out_valid || first_of_frame))
    else $error("frame continues past last byte");

  // an idle back part has no queued byte left waiting
  assert property (@(posedge clk) disable iff (rst)
    (!status.busy && q_head.valid) |-> q_pop)
    else $error("idle back part ignores queued byte");

endmodule

// ===== tb/tb_sensor_frame_resync_parser.sv =====
// Testbench for sensor_frame_resync_parser: directed and random byte streams,
// self-checking against an in-bench frame parser predictor.
// Depends on sfr_pkg and the parser RTL.
`timescale 1ns / 1ps
module tb_sensor_frame_resync_parser;

  localparam int MAX_EMIT = 64;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic [7:0] mtype;
    logic [1:0] kind;
  } frame_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic       cfg_index = sfr_pkg::REG_START_MARKER;
  logic [7:0] cfg_data = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       first_of_frame;
  logic       last_of_frame;
  logic [7:0] message_type;
  logic [1:0] frame_kind;

  sensor_frame_resync_parser uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
    .first_of_frame(first_of_frame), .last_of_frame(last_of_frame),
    .message_type(message_type), .frame_kind(frame_kind)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // predictor state: its own copy of markers and the circular byte buffer
  logic [7:0] pm_start, pm_end;
  logic [7:0] pm_buf[sfr_pkg::BUFFER_BYTES];
  int         pm_fill, pm_head;

  logic [7:0]  pending_bytes[$];  // bytes waiting for the driver
  frame_byte_t expected_bytes[$]; // predicted output transfers
  int          errors = 0;
  int          sent = 0, received = 0, frames_seen = 0;
  int          idle_cycles = 0;
  bit          hold_input = 1'b0;
  int          in_gap = 0, out_gap = 0;

  function automatic void add_byte(logic [7:0] b);
    pending_bytes.insert(pending_bytes.size(), b);
  endfunction

  function automatic logic [7:0] buf_at(int off);
    return pm_buf[(pm_head + off) % sfr_pkg::BUFFER_BYTES];
  endfunction

  function automatic void drop_bytes(int n);
    pm_head = (pm_head + n) % sfr_pkg::BUFFER_BYTES;
    pm_fill -= n;
  endfunction

  function automatic void hunt_start();
    while (pm_fill > 0 && buf_at(0) != pm_start) drop_bytes(1);
  endfunction

  // push one received byte, queue every frame byte it releases
  function automatic void parse_byte(logic [7:0] b);
    int          emitted;
    int          total;
    logic [7:0]  sum;
    frame_byte_t fb;
    emitted = 0;
    if (pm_fill >= sfr_pkg::BUFFER_BYTES) drop_bytes(1);
    pm_buf[(pm_head + pm_fill) % sfr_pkg::BUFFER_BYTES] = b;
    pm_fill++;
    hunt_start();
    while (pm_fill >= sfr_pkg::FRAME_OVERHEAD) begin
      total = sfr_pkg::FRAME_OVERHEAD + buf_at(2);
      if (total > MAX_EMIT) begin
        drop_bytes(1);
        hunt_start();
        continue;
      end
      if (pm_fill < total) break;
      sum = 8'h00;
      for (int i = 0; i + 2 < total; i++) sum += buf_at(i);
      if (buf_at(total - 1) != pm_end || buf_at(total - 2) != sum) begin
        drop_bytes(1);
        hunt_start();
        continue;
      end
      if (emitted + total > MAX_EMIT) break;
      for (int i = 0; i < total; i++) begin
        fb.data  = buf_at(i);
        fb.first = (i == 0);
        fb.last  = (i == total - 1);
        fb.mtype = buf_at(1);
        fb.kind  = (buf_at(1) == sfr_pkg::TYPE_STATUS) ? sfr_pkg::KIND_STATUS :
                   (buf_at(1) == sfr_pkg::TYPE_RADAR) ? sfr_pkg::KIND_RADAR :
                   sfr_pkg::KIND_UNKNOWN;
        expected_bytes.insert(expected_bytes.size(), fb);
        emitted++;
      end
      drop_bytes(total);
      hunt_start();
    end
  endfunction

  // queue a well-formed frame; corrupt: 0 clean, 1 bad checksum, 2 bad end marker
  task automatic queue_frame(logic [7:0] mtype, int n_body, int corrupt);
    logic [7:0] sum;
    logic [7:0] b;
    sum = pm_start + mtype + 8'(n_body);
    add_byte(pm_start);
    add_byte(mtype);
    add_byte(8'(n_body));
    for (int i = 0; i < n_body; i++) begin
      b = 8'($urandom);
      sum += b;
      add_byte(b);
    end
    add_byte(corrupt == 1 ? sum ^ 8'h01 : sum);
    add_byte(corrupt == 2 ? ~pm_end : pm_end);
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // driver: one transfer per accepted byte; valid held until taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) sent++;
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (!hold_input && pending_bytes.size() > 0) begin
        in_byte <= pending_bytes[0];
        parse_byte(pending_bytes.pop_front());
        in_valid <= 1'b1;
        in_gap <= gap_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: compare each output transfer with the oldest prediction
  always @(posedge clk) begin
    frame_byte_t exp_fb;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        received++;
        if (expected_bytes.size() == 0) begin
          $error("unexpected output byte %02h", out_byte);
          errors++;
        end else begin
          exp_fb = expected_bytes.pop_front();
          if (out_byte !== exp_fb.data) begin
            $error("out_byte exp %02h got %02h", exp_fb.data, out_byte); errors++;
          end
          if (first_of_frame !== exp_fb.first) begin
            $error("first_of_frame exp %0b got %0b", exp_fb.first, first_of_frame); errors++;
          end
          if (last_of_frame !== exp_fb.last) begin
            $error("last_of_frame exp %0b got %0b", exp_fb.last, last_of_frame); errors++;
          end
          if (message_type !== exp_fb.mtype) begin
            $error("message_type exp %02h got %02h", exp_fb.mtype, message_type); errors++;
          end
          if (frame_kind !== exp_fb.kind) begin
            $error("frame_kind exp %0d got %0d", exp_fb.kind, frame_kind); errors++;
          end
          if (exp_fb.last) frames_seen++;
        end
      end
      // random stall on the result side, sometimes a long one
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_gap <= gap_len();
        out_stall <= 1'b0;
      end
      // watchdog: cycles with no transfer on either side
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("tb_sensor_frame_resync_parser failed");
      $finish;
    end
  end

  // wait until the bench has drained all stimulus and all predictions
  task automatic wait_drained();
    while (pending_bytes.size() > 0 || in_valid) @(posedge clk);
    while (expected_bytes.size() > 0) @(posedge clk);
    // bytes that form no frame can still be queued or under scan
    while (uut.q_head.valid || uut.status.busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == sfr_pkg::REG_START_MARKER) pm_start = val;
    else pm_end = val;
  endtask

  task automatic random_phase(int n_items);
    int r;
    int queued;
    int base;
    queued = 0;
    base = sent + pending_bytes.size();
    while (queued < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        queue_frame(8'($urandom_range(0, 2) == 0 ? sfr_pkg::TYPE_STATUS :
                       $urandom_range(0, 1) ? sfr_pkg::TYPE_RADAR : $urandom),
                    $urandom_range(0, 99) < 90 ? $urandom_range(0, 8)
                                               : $urandom_range(0, 59), 0);
      end else if (r < 75) begin
        queue_frame(8'($urandom), $urandom_range(0, 6), $urandom_range(1, 2));
      end else if (r < 80) begin
        // oversize length field
        add_byte(pm_start);
        add_byte(8'($urandom));
        add_byte(8'($urandom_range(60, 255)));
      end else begin
        repeat ($urandom_range(1, 4)) add_byte(8'($urandom));
      end
      queued = sent + pending_bytes.size() - base;
      while (pending_bytes.size() > 8) @(posedge clk);
    end
  endtask

  initial begin
    pm_start = 8'h00;
    pm_end = 8'h00;
    pm_fill = 0;
    pm_head = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset markers (both zero) first, then a typical marker pair
    queue_frame(sfr_pkg::TYPE_STATUS, 0, 0);
    wait_drained();
    write_reg(sfr_pkg::REG_START_MARKER, 8'hAA);
    write_reg(sfr_pkg::REG_END_MARKER, 8'h55);

    // directed: each type class, empty and max body, bad sum, bad end,
    // oversize length, leading garbage
    add_byte(8'h00);
    add_byte(8'hFF);
    queue_frame(sfr_pkg::TYPE_STATUS, 1, 0);
    queue_frame(sfr_pkg::TYPE_RADAR, 2, 0);
    queue_frame(8'hFF, 0, 0);
    queue_frame(8'h00, 1, 1);
    queue_frame(sfr_pkg::TYPE_RADAR, 1, 2);
    add_byte(8'hAA);
    add_byte(8'h62);
    add_byte(8'hFF);
    queue_frame(sfr_pkg::TYPE_STATUS, 59, 0);
    // sender pauses until every expected byte is out
    hold_input = 1'b1;
    while (in_valid) @(posedge clk);
    while (expected_bytes.size() > 0) @(posedge clk);
    hold_input = 1'b0;
    wait_drained();

    random_phase(110);
    wait_drained();

    // extreme marker values
    write_reg(sfr_pkg::REG_START_MARKER, 8'hFF);
    write_reg(sfr_pkg::REG_END_MARKER, 8'h00);
    random_phase(60);
    wait_drained();

    write_reg(sfr_pkg::REG_START_MARKER, 8'h00);
    write_reg(sfr_pkg::REG_END_MARKER, 8'hFF);
    random_phase(60);
    wait_drained();

    $display("run covered %0d input bytes, %0d output bytes, %0d frames",
             sent, received, frames_seen);
    $display("marker settings: reset, AA/55, FF/00, 00/FF");
    if (errors == 0) begin
      $display("tb_sensor_frame_resync_parser passed");
    end else begin
      $display("tb_sensor_frame_resync_parser failed");
    end
    $finish;
  end

endmodule
